>>> rtl/cache_set_lru_stack_unit_assert.svh
// Assertion macros shared by the cache set LRU stack RTL.
`ifndef CACHE_SET_LRU_STACK_UNIT_ASSERT_SVH
`define CACHE_SET_LRU_STACK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted.
`define CSLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define CSLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSLS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSLS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/csls_pkg.sv
// Types, constants and helpers for the cache set LRU stack.
package csls_pkg;

  localparam int ASSOC     = 8;
  localparam int TAG_BITS  = 40;
  localparam int POS_W     = $clog2(ASSOC);
  localparam int IN_TAG_W  = 40;
  localparam int IN_POS_W  = 3;
  localparam int OUT_POS_W = 3;

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [POS_W-1:0]    way_idx_t;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_PROMOTE = 2'd1,
    CMD_DEMOTE  = 2'd2,
    CMD_WRITE   = 2'd3
  } cmd_code_t;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;   // run the command and capture its result
  } dp_cmd_t;

  // Fit the port tag to the stored tag width (truncate or zero-extend).
  function automatic tag_t to_tag(logic [IN_TAG_W-1:0] t);
    tag_t r;
    r = '0;
    for (int i = 0; i < TAG_BITS; i++) begin
      if (i < IN_TAG_W) begin
        r[i] = t[i];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/cache_set_lru_stack_unit.sv
// Top level of the cache set LRU stack: one set of ways in recency order.
//
// Usage:
//   Input stream (in_*): one command word per handshake. in_tuser carries the
//   command (lookup, promote to head, demote to tail, write entry); in_tdata
//   carries the tag, stack position and valid bit for that command.
//   Result stream (out_*): exactly one result word per command. out_tuser is
//   the hit flag, out_tdata the lowest matching position; both are zero for other commands.
//   Latency: the result is shown the cycle after the command is accepted.
//   Throughput: one command per cycle while results are taken; every command,
//   including a rotation, completes as it is accepted through parallel tag
//   compares and neighbour shifts across all ways.
//   Stall: a result that is not taken waits in the output register; a new
//   command is still taken in the cycle the held result leaves, otherwise
//   in_tready drops until out_tready returns.
//   Reset (rst_n low, synchronous): every way is cleared to invalid with a
//   zero tag and the output register is emptied. No clearing pass follows.
//   Positions at or beyond the set size leave the stack untouched.
module cache_set_lru_stack_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [39:0] lookup_tag, [42:40] stack_position,
                                  // [43] entry_valid, [47:44] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] hit_position, [7:3] zero
  output logic        out_tuser   // [0] hit
);
  import csls_pkg::*;

  dp_cmd_t              dp_cmd;
  logic [OUT_POS_W-1:0] hit_position;

  csls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd)
  );

  csls_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .command        (cmd_code_t'(in_tuser)),
    .lookup_tag     (in_tdata[39:0]),
    .stack_position (in_tdata[42:40]),
    .entry_valid    (in_tdata[43]),
    .hit            (out_tuser),
    .hit_position   (hit_position)
  );

  assign out_tdata = {5'd0, hit_position};

endmodule

>>> rtl/csls_ctrl.sv
// Handshake controller: output word register occupancy and accept control.
`include "cache_set_lru_stack_unit_assert.svh"

module csls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output csls_pkg::dp_cmd_t dp_cmd
);
  import csls_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_tready   = 1'b1;
    out_tvalid  = 1'b0;
    accept      = 1'b0;
    state_nxt   = state_r;
    case (state_r)
      ST_EMPTY: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (accept) begin
          state_nxt = ST_FULL;
        end
      end
      ST_FULL: begin
        out_tvalid = 1'b1;
        in_tready  = out_tready;   // slot frees as the held word leaves
        accept     = in_tvalid && out_tready;
        if (out_tready && !accept) begin
          state_nxt = ST_EMPTY;
        end
      end
      default: begin
        state_nxt = ST_EMPTY;
      end
    endcase
    dp_cmd.exec = accept;
  end

  `CSLS_ASSERT(a_accept_gives_word, clk, rst_n, (in_tvalid && in_tready) |=> out_tvalid, "accepted word produced no result")
  `CSLS_ASSERT(a_empty_ready, clk, rst_n, !out_tvalid |-> in_tready, "empty output but input stalled")
  `CSLS_ASSERT(a_drain, clk, rst_n, (out_tvalid && out_tready && !in_tvalid) |=> !out_tvalid, "result repeated after drain")

endmodule

>>> rtl/csls_datapath.sv
// Way stack registers, parallel tag compare and rotate/write logic.
`include "cache_set_lru_stack_unit_assert.svh"

module csls_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  csls_pkg::dp_cmd_t                  dp_cmd,
  input  csls_pkg::cmd_code_t                command,
  input  logic [csls_pkg::IN_TAG_W-1:0]      lookup_tag,
  input  logic [csls_pkg::IN_POS_W-1:0]      stack_position,
  input  logic                               entry_valid,
  output logic                               hit,
  output logic [csls_pkg::OUT_POS_W-1:0]     hit_position
);
  import csls_pkg::*;

  tag_t             tags_r [ASSOC];
  tag_t             tags_nxt [ASSOC];
  logic [ASSOC-1:0] vld_r, vld_nxt;
  logic             hit_r;
  logic [OUT_POS_W-1:0] hit_pos_r;

  tag_t                 tag_c;
  way_idx_t             idx;
  logic                 in_set;
  tag_t                 sel_tag;
  logic                 sel_vld;
  logic                 match_c;
  logic [OUT_POS_W-1:0] match_pos_c;

  assign tag_c   = to_tag(lookup_tag);
  assign idx     = POS_W'(stack_position);
  assign in_set  = (32'(stack_position) < ASSOC);
  assign sel_tag = tags_r[idx];
  assign sel_vld = vld_r[idx];

  // Lowest matching valid way wins.
  always_comb begin
    match_c     = 1'b0;
    match_pos_c = '0;
    for (int i = ASSOC - 1; i >= 0; i--) begin
      if (vld_r[i] && (tags_r[i] == tag_c)) begin
        match_c     = 1'b1;
        match_pos_c = OUT_POS_W'(i);
      end
    end
  end

  always_comb begin
    tags_nxt = tags_r;
    vld_nxt  = vld_r;
    case (command)
      CMD_PROMOTE: begin
        if (in_set) begin
          for (int i = 0; i < ASSOC; i++) begin
            if (i == 0) begin
              tags_nxt[i] = sel_tag;
              vld_nxt[i]  = sel_vld;
            end else if (i <= int'(idx)) begin
              tags_nxt[i] = tags_r[i-1];
              vld_nxt[i]  = vld_r[i-1];
            end
          end
        end
      end
      CMD_DEMOTE: begin
        if (in_set) begin
          for (int i = 0; i < ASSOC; i++) begin
            if (i == ASSOC - 1) begin
              tags_nxt[i] = sel_tag;
              vld_nxt[i]  = sel_vld;
            end else if (i >= int'(idx)) begin
              tags_nxt[i] = tags_r[i+1];
              vld_nxt[i]  = vld_r[i+1];
            end
          end
        end
      end
      CMD_WRITE: begin
        if (in_set) begin
          tags_nxt[idx] = tag_c;
          vld_nxt[idx]  = entry_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      for (int i = 0; i < ASSOC; i++) begin
        tags_r[i] <= '0;
      end
    end else if (dp_cmd.exec) begin
      vld_r  <= vld_nxt;
      tags_r <= tags_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r     <= 1'b0;
      hit_pos_r <= '0;
    end else if (dp_cmd.exec) begin
      hit_r     <= (command == CMD_LOOKUP) && match_c;
      hit_pos_r <= (command == CMD_LOOKUP) ? match_pos_c : '0;
    end
  end

  assign hit          = hit_r;
  assign hit_position = hit_pos_r;

  `CSLS_ASSERT(a_idle_state_holds, clk, rst_n, !dp_cmd.exec |=> $stable(vld_r), "valid bits changed without a command")
  `CSLS_ASSERT(a_idle_result_holds, clk, rst_n, !dp_cmd.exec |=> ($stable(hit_r) && $stable(hit_pos_r)), "result changed while held")
  `CSLS_ASSERT(a_rotate_keeps_valids, clk, rst_n, (dp_cmd.exec && (command == CMD_PROMOTE || command == CMD_DEMOTE)) |=> ($countones(vld_r) == $past($countones(vld_r))), "rotation lost or gained a valid way")

endmodule
